[rtl/svalloc_pkg.sv]
// ----------------------------------------------------------------------------
// svalloc_pkg
// Shared types and constants for the voice allocator: voice table entry,
// request codes, control state and derived widths.
// ----------------------------------------------------------------------------
package svalloc_pkg;

	localparam int NUM_VOICES = 16;
	// voice index width, at least one bit
	localparam int VIDX_W = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
	// scan counter must also hold NUM_VOICES itself
	localparam int CNT_W = $clog2(NUM_VOICES + 1);

	localparam logic [1:0] REQ_DOWN   = 2'd0;
	localparam logic [1:0] REQ_UP     = 2'd1;
	localparam logic [1:0] REQ_STATUS = 2'd2;

	typedef struct packed {
		logic        active;
		logic        released;
		logic        in_release;
		logic [6:0]  note;
		logic [31:0] level;
	} voice_ent_t;

	localparam int ENT_W = $bits(voice_ent_t);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SREAD,
		ST_SCAN,
		ST_FINISH
	} ctl_state_t;

endpackage

[rtl/svalloc_ram.sv]
// ----------------------------------------------------------------------------
// svalloc_ram
// Generic single-write, single-read RAM with registered read data that holds
// while no read is issued.
// ----------------------------------------------------------------------------
module svalloc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

[rtl/synth_voice_allocator_core.sv]
// ----------------------------------------------------------------------------
// synth_voice_allocator_core
// Item flow: note down / note up scan the voice table (ST_SCAN), then the
//   result register loads (ST_FINISH); status items read their voice first
//   (ST_SREAD); unused items and status for a missing voice go to ST_FINISH.
// One item at a time: no new item is accepted until the result has loaded;
//   the scan reads one voice per cycle on the single read port of the voice
//   table, and a stalled result holds the item in ST_FINISH.
// Reset: arst_n clears control, output valid and the per-voice valid bits;
//   no clearing pass, an entry never written reads as an idle voice.
// ----------------------------------------------------------------------------
module synth_voice_allocator_core (
	input  logic        clk,
	input  logic        arst_n,
	// request channel
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  req_type,
	input  logic [6:0]  pitch,
	input  logic [3:0]  voice_sel,
	input  logic        upd_active,
	input  logic        upd_in_release,
	input  logic [31:0] upd_level,
	// result channel
	output logic        out_valid,
	input  logic        out_stall,
	output logic        granted,
	output logic        stolen,
	output logic [3:0]  voice_out,
	output logic [15:0] release_mask
);
	import svalloc_pkg::*;

	// ---------------- control state ----------------
	ctl_state_t state_q, state_nx;
	logic       in_acc;
	logic       sel_ok;        // status item aimed at an existing voice
	logic       out_load;      // result register takes this item's result

	// request held for the whole item
	logic [1:0]        req_q;
	logic [6:0]        pitch_q;
	logic [VIDX_W-1:0] sel_addr_q;
	logic              sel_ok_q;
	logic              upd_active_q;
	logic              upd_in_release_q;
	logic [31:0]       upd_level_q;

	// scan address counter and read pipeline
	logic [CNT_W-1:0]  cnt_q;
	logic              scan_more;
	logic              rd_en;
	logic [VIDX_W-1:0] rd_addr;
	logic              rd_vld_s1;  // read data arrives this cycle
	logic [VIDX_W-1:0] addr_s1;
	logic              ent_vld_s1; // entry had been written
	logic [ENT_W-1:0]  rd_data;
	voice_ent_t        cur;

	// search results
	logic              have_free_q;
	logic [VIDX_W-1:0] free_v_q;
	logic              have_rel_q;
	logic [VIDX_W-1:0] rel_v_q;
	logic [31:0]       rel_lvl_q;
	logic [15:0]       mask_q;

	// table write port
	logic              wr_en;
	logic [VIDX_W-1:0] wr_addr;
	voice_ent_t        wr_ent;

	// per-entry written marks; an unwritten entry reads as all zero
	logic [NUM_VOICES-1:0] ent_vld_q;

	// result register
	logic        out_valid_q;
	logic        granted_q;
	logic        stolen_q;
	logic [3:0]  voice_out_q;
	logic [15:0] release_mask_q;

	logic        fin_grant;
	logic        fin_steal;
	logic [VIDX_W-1:0] fin_voice;
	logic        scan_hit;     // note up matches the entry just read

	assign in_acc    = in_valid && !in_stall;
	assign sel_ok    = (int'(voice_sel) < NUM_VOICES);
	assign scan_more = (cnt_q < CNT_W'(NUM_VOICES));
	assign cur       = ent_vld_s1 ? voice_ent_t'(rd_data) : voice_ent_t'('0);

	// free voice wins; otherwise the quietest releasing voice is stolen
	assign fin_grant = have_free_q || have_rel_q;
	assign fin_steal = !have_free_q && have_rel_q;
	assign fin_voice = have_free_q ? free_v_q : rel_v_q;

	assign scan_hit = (state_q == ST_SCAN) && rd_vld_s1 && (req_q == REQ_UP)
		&& cur.active && (cur.note == pitch_q);

	// ---------------- next state ----------------
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					priority if (req_type == REQ_DOWN || req_type == REQ_UP) begin
						state_nx = ST_SCAN;
					end else if (req_type == REQ_STATUS && sel_ok) begin
						state_nx = ST_SREAD;
					end else begin
						state_nx = ST_FINISH;
					end
				end
			end
			ST_SREAD: state_nx = ST_FINISH;
			ST_SCAN: begin
				// last read data consumed, nothing in flight
				if (!scan_more && !rd_vld_s1) begin
					state_nx = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (out_load) begin
					state_nx = ST_IDLE;
				end
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	// ---------------- control outputs ----------------
	always_comb begin
		in_stall = (state_q != ST_IDLE);
		out_load = (state_q == ST_FINISH) && (!out_valid_q || !out_stall);
		rd_en    = 1'b0;
		rd_addr  = sel_addr_q;
		wr_en    = 1'b0;
		wr_addr  = addr_s1;
		wr_ent   = cur;
		unique case (state_q)
			ST_IDLE: ;
			ST_SREAD: begin
				rd_en = 1'b1;
			end
			ST_SCAN: begin
				rd_en   = scan_more;
				rd_addr = cnt_q[VIDX_W-1:0];
				// note up: mark the matching voice released, in place
				if (scan_hit) begin
					wr_en           = 1'b1;
					wr_ent.released = 1'b1;
				end
			end
			ST_FINISH: begin
				if (req_q == REQ_DOWN) begin
					// envelope restart on the chosen voice
					wr_en             = out_load && fin_grant;
					wr_addr           = fin_voice;
					wr_ent.active     = 1'b1;
					wr_ent.released   = 1'b0;
					wr_ent.in_release = 1'b0;
					wr_ent.note       = pitch_q;
					wr_ent.level      = '0;
				end else begin
					// status: keep note and release request, replace the rest
					wr_en             = out_load && (req_q == REQ_STATUS) && sel_ok_q;
					wr_addr           = sel_addr_q;
					wr_ent.active     = upd_active_q;
					wr_ent.in_release = upd_in_release_q;
					wr_ent.level      = upd_level_q;
				end
			end
			default: ;
		endcase
	end

	// ---------------- voice table ----------------
	svalloc_ram #(
		.WIDTH (ENT_W),
		.DEPTH (NUM_VOICES)
	) u_tab (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (ENT_W'(wr_ent)),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// ---------------- control registers ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			rd_vld_s1   <= 1'b0;
			ent_vld_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q   <= state_nx;
			rd_vld_s1 <= rd_en;
			if (in_acc) begin
				cnt_q <= '0;
			end else if (state_q == ST_SCAN && scan_more) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
			if (wr_en) begin
				ent_vld_q[wr_addr] <= 1'b1;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// ---------------- datapath registers ----------------
	always_ff @(posedge clk) begin
		if (in_acc) begin
			req_q            <= req_type;
			pitch_q          <= pitch;
			sel_addr_q       <= VIDX_W'(voice_sel);
			sel_ok_q         <= sel_ok;
			upd_active_q     <= upd_active;
			upd_in_release_q <= upd_in_release;
			upd_level_q      <= upd_level;
			have_free_q      <= 1'b0;
			have_rel_q       <= 1'b0;
			free_v_q         <= '0;
			rel_v_q          <= '0;
			rel_lvl_q        <= '0;
			mask_q           <= '0;
		end
		if (rd_en) begin
			addr_s1    <= rd_addr;
			ent_vld_s1 <= ent_vld_q[rd_addr];
		end
		// note down search: first idle voice, else quietest releasing one
		if (state_q == ST_SCAN && rd_vld_s1 && req_q == REQ_DOWN && !have_free_q) begin
			if (!cur.active) begin
				have_free_q <= 1'b1;
				free_v_q    <= addr_s1;
			end else if (cur.in_release && (!have_rel_q || cur.level < rel_lvl_q)) begin
				have_rel_q <= 1'b1;
				rel_v_q    <= addr_s1;
				rel_lvl_q  <= cur.level;
			end
		end
		// only voices 0..15 show in the mask
		if (scan_hit && int'(addr_s1) < 16) begin
			mask_q[4'(addr_s1)] <= 1'b1;
		end
		if (out_load) begin
			granted_q      <= (req_q == REQ_DOWN) && fin_grant;
			stolen_q       <= (req_q == REQ_DOWN) && fin_steal;
			voice_out_q    <= ((req_q == REQ_DOWN) && fin_grant) ? 4'(fin_voice) : 4'd0;
			release_mask_q <= (req_q == REQ_UP) ? mask_q : 16'd0;
		end
	end

	assign out_valid    = out_valid_q;
	assign granted      = granted_q;
	assign stolen       = stolen_q;
	assign voice_out    = voice_out_q;
	assign release_mask = release_mask_q;

endmodule

[rtl/svalloc_checker.sv]
// ----------------------------------------------------------------------------
// svalloc_checker
// Port-level checks on the voice allocator, bound to the top level.
// ----------------------------------------------------------------------------
module svalloc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic [1:0]  req_type,
	input logic [6:0]  pitch,
	input logic [3:0]  voice_sel,
	input logic        upd_active,
	input logic        upd_in_release,
	input logic [31:0] upd_level,
	input logic        out_valid,
	input logic        out_stall,
	input logic        granted,
	input logic        stolen,
	input logic [3:0]  voice_out,
	input logic [15:0] release_mask
);

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(granted) && $stable(stolen)
			&& $stable(voice_out) && $stable(release_mask))
		else $error("result changed while stalled");

	// one item at a time: busy right after an accept
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("item accepted while previous one in work");

	// no grant means no steal and voice zero
	a_nogrant: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !granted |-> !stolen && voice_out == 4'd0)
		else $error("steal or voice without grant");

	// grant and release mask come from different request types
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && granted |-> release_mask == 16'd0)
		else $error("grant with release mask");

endmodule

bind synth_voice_allocator_core svalloc_checker u_svalloc_checker (.*);
